@@ rtl/pcmrc_pkg.sv @@
package pcmrc_pkg;

   // Position format: FRAC_BITS fraction bits, room for position plus step.
   localparam int FRAC_BITS = 16;
   localparam int STEP_W    = FRAC_BITS + 3;
   localparam int POS_W     = FRAC_BITS + 4;
   localparam logic [POS_W-1:0] POS_ONE = POS_W'(1) << FRAC_BITS;

   localparam int SAMPLE_W = 16;
   localparam int WORD_W   = 32;
   localparam int WIDTH_W  = 2;
   localparam int FILL_W   = 2;

   localparam int MAX_BURST = 4;
   localparam int BURST_W   = 3;

   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   // Register indexes on paddr[3:2].
   typedef enum logic [1:0] {
      REG_STEP_FRAC = 2'd0,
      REG_IN_WIDTH  = 2'd1,
      REG_OUT_WIDTH = 2'd2,
      REG_NONE      = 2'd3
   } reg_index_type;

   // Width code for one-byte samples; any other code means two bytes.
   localparam logic [WIDTH_W-1:0] WIDTH_BYTE = 2'd1;
   localparam logic [WIDTH_W-1:0] WIDTH_HALF = 2'd2;

   localparam logic [STEP_W-1:0] STEP_RESET = STEP_W'(POS_ONE);

endpackage

@@ rtl/pcm_rate_converter_packer.sv @@
// Sample-and-hold PCM rate converter with 32-bit word packer.
// Source samples enter on the req_ channel (valid/ready), one mono sample per
// transfer, 8-bit unsigned or 16-bit signed as set by in_width. Packed words
// leave on the rsp_ channel (valid/ready), earliest sample in the low bits,
// two 16-bit or four 8-bit samples per word as set by out_width. The last
// source sample flushes a zero-padded partial word flagged with last_word.
// step_frac, in_width and out_width sit on the APB port at 0x0, 0x4, 0x8;
// write them only while the block is idle. Writing out_width drops any
// partial word.
// Each sample passes through these steps before the next transfer: capture,
// a step for each output position (at most four) through the shared position
// adder, a step to settle the position, and a flush step on the last sample.
// A finished word waits in the output register; when rsp_ready is low and
// another word completes, the sequencer holds in place until the output
// register drains.
// Reset (synchronous, active high) restores the register defaults (unity
// step, 16-bit in and out), clears the position and the partial word, and
// empties the output register.
module pcm_rate_converter_packer
   import pcmrc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   // source samples
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [SAMPLE_W-1:0]   req_source_sample,
   input  logic                  req_last_sample,
   // packed words
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [WORD_W-1:0]     rsp_packed_word,
   output logic                  rsp_last_word,
   // configuration
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_STEP,
      ST_FLUSH
   } state_type;

   state_type             state_ff, state_in;
   logic [STEP_W-1:0]     step_frac_ff, step_frac_in;
   logic [WIDTH_W-1:0]    in_width_ff, in_width_in;
   logic [WIDTH_W-1:0]    out_width_ff, out_width_in;
   logic [POS_W-1:0]      pos_ff, pos_in;
   logic [WORD_W-1:0]     buf_ff, buf_in;
   logic [FILL_W-1:0]     fill_ff, fill_in;
   logic [BURST_W-1:0]    burst_ff, burst_in;
   logic [SAMPLE_W-1:0]   sample_ff, sample_in;
   logic                  last_ff, last_in;
   logic                  emitted_ff, emitted_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [WORD_W-1:0]     rsp_word_ff, rsp_word_in;
   logic                  rsp_last_ff, rsp_last_in;

   reg_index_type         csr_index;
   logic                  csr_write;
   logic                  out_free;
   logic                  narrow;
   logic                  fill_full;
   logic [POS_W-1:0]      pos_sum;
   logic                  more;
   logic [4:0]            shift;
   logic [WORD_W-1:0]     slot_bits;
   logic [WORD_W-1:0]     new_buf;
   logic [SAMPLE_W-1:0]   widened;

   assign csr_index = reg_index_type'(paddr[3:2]);
   assign csr_write = psel && penable && pwrite;
   assign pready    = 1'b1;

   always_comb begin
      case (csr_index)
         REG_STEP_FRAC: prdata = CSR_DATA_W'(step_frac_ff);
         REG_IN_WIDTH:  prdata = CSR_DATA_W'(in_width_ff);
         REG_OUT_WIDTH: prdata = CSR_DATA_W'(out_width_ff);
         default:       prdata = '0;
      endcase
   end

   assign req_ready       = (state_ff == ST_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_packed_word = rsp_word_ff;
   assign rsp_last_word   = rsp_last_ff;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign narrow    = (out_width_ff == WIDTH_BYTE);
   assign fill_full = narrow ? (fill_ff == FILL_W'(3)) : (fill_ff == FILL_W'(1));

   // Shared position adder.
   assign pos_sum = pos_ff + POS_W'(step_frac_ff);
   assign more    = (pos_sum < POS_ONE) && (burst_ff != BURST_W'(MAX_BURST - 1));

   assign shift     = narrow ? {fill_ff, 3'b000} : {fill_ff[0], 4'b0000};
   assign slot_bits = narrow ? WORD_W'(sample_ff[15:8]) : WORD_W'(sample_ff);
   assign new_buf   = buf_ff | (slot_bits << shift);

   // Unsigned byte to signed 16-bit: flip the sign bit, move to the top.
   assign widened = (in_width_ff == WIDTH_BYTE) ?
                    {~req_source_sample[7], req_source_sample[6:0], 8'h00} :
                    req_source_sample;

   always_comb begin
      state_in     = state_ff;
      step_frac_in = step_frac_ff;
      in_width_in  = in_width_ff;
      out_width_in = out_width_ff;
      pos_in       = pos_ff;
      buf_in       = buf_ff;
      fill_in      = fill_ff;
      burst_in     = burst_ff;
      sample_in    = sample_ff;
      last_in      = last_ff;
      emitted_in   = emitted_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_word_in  = rsp_word_ff;
      rsp_last_in  = rsp_last_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               sample_in  = widened;
               last_in    = req_last_sample;
               burst_in   = '0;
               emitted_in = 1'b0;
               state_in   = ST_STEP;
            end
         end
         ST_STEP: begin
            if (pos_ff < POS_ONE && burst_ff != BURST_W'(MAX_BURST)) begin
               // hold when a word completes and the output register is busy
               if (!fill_full || out_free) begin
                  if (fill_full) begin
                     rsp_valid_in = 1'b1;
                     rsp_word_in  = new_buf;
                     rsp_last_in  = last_ff && !more;
                     buf_in       = '0;
                     fill_in      = '0;
                     emitted_in   = 1'b1;
                  end else begin
                     buf_in  = new_buf;
                     fill_in = fill_ff + FILL_W'(1);
                  end
                  pos_in   = pos_sum;
                  burst_in = burst_ff + BURST_W'(1);
               end
            end else begin
               if (last_ff) begin
                  pos_in   = '0;
                  state_in = ST_FLUSH;
               end else begin
                  pos_in   = (pos_ff >= POS_ONE) ? pos_ff - POS_ONE : '0;
                  state_in = ST_IDLE;
               end
            end
         end
         ST_FLUSH: begin
            if (fill_ff != '0 || !emitted_ff) begin
               if (out_free) begin
                  rsp_valid_in = 1'b1;
                  rsp_word_in  = (fill_ff != '0) ? buf_ff : '0;
                  rsp_last_in  = 1'b1;
                  buf_in       = '0;
                  fill_in      = '0;
                  state_in     = ST_IDLE;
               end
            end else begin
               buf_in   = '0;
               fill_in  = '0;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      if (csr_write) begin
         case (csr_index)
            REG_STEP_FRAC: step_frac_in = pwdata[STEP_W-1:0];
            REG_IN_WIDTH:  in_width_in  = pwdata[WIDTH_W-1:0];
            REG_OUT_WIDTH: begin
               out_width_in = pwdata[WIDTH_W-1:0];
               buf_in       = '0;
               fill_in      = '0;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_frac_ff <= STEP_RESET;
         in_width_ff  <= WIDTH_HALF;
         out_width_ff <= WIDTH_HALF;
         pos_ff       <= '0;
         buf_ff       <= '0;
         fill_ff      <= '0;
         burst_ff     <= '0;
         last_ff      <= 1'b0;
         emitted_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_frac_ff <= step_frac_in;
         in_width_ff  <= in_width_in;
         out_width_ff <= out_width_in;
         pos_ff       <= pos_in;
         buf_ff       <= buf_in;
         fill_ff      <= fill_in;
         burst_ff     <= burst_in;
         last_ff      <= last_in;
         emitted_ff   <= emitted_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      sample_ff   <= sample_in;
      rsp_word_ff <= rsp_word_in;
      rsp_last_ff <= rsp_last_in;
   end

endmodule

@@ tb/tb.sv @@
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import pcmrc_pkg::*;

   typedef struct packed {
      logic [WORD_W-1:0] word;
      logic              last;
   } packed_result_type;

   class pcm_word_scoreboard;
      logic [STEP_W-1:0]  step;
      logic [WIDTH_W-1:0] in_code;
      logic [WIDTH_W-1:0] out_code;
      logic [POS_W-1:0]   position;
      logic [WORD_W-1:0]  buffer;
      int                 fill;
      packed_result_type  expected_words[$];
      int                 errors;

      function new();
         errors = 0;
         reset_state();
      endfunction

      function void reset_state();
         step = STEP_RESET;
         in_code = WIDTH_HALF;
         out_code = WIDTH_HALF;
         position = '0;
         buffer = '0;
         fill = 0;
         expected_words.delete();
      endfunction

      function int pending();
         return expected_words.size();
      endfunction

      function void apply_register(reg_index_type idx, logic [CSR_DATA_W-1:0] value);
         case (idx)
            REG_STEP_FRAC: step = value[STEP_W-1:0];
            REG_IN_WIDTH:  in_code = value[WIDTH_W-1:0];
            REG_OUT_WIDTH: begin
               // a new output width drops the partial word
               out_code = value[WIDTH_W-1:0];
               buffer = '0;
               fill = 0;
            end
            default: ;
         endcase
      endfunction

      // Note an accepted source sample and queue the words it completes.
      function void take_sample(logic [SAMPLE_W-1:0] raw, logic is_last);
         logic [SAMPLE_W-1:0] s16;
         packed_result_type   item_words[$];
         packed_result_type   w;
         bit                  narrow;
         int                  burst;
         s16 = (in_code == WIDTH_BYTE) ? {raw[7:0] ^ 8'h80, 8'h00} : raw;
         narrow = (out_code == WIDTH_BYTE);
         burst = 0;
         while (position < POS_ONE && burst < MAX_BURST) begin
            if (narrow)
               buffer |= {24'b0, s16[15:8]} << (8 * fill);
            else
               buffer |= {16'b0, s16} << (16 * fill);
            fill++;
            if (fill == (narrow ? 4 : 2)) begin
               w.word = buffer;
               w.last = 1'b0;
               item_words.push_back(w);
               buffer = '0;
               fill = 0;
            end
            position = position + POS_W'(step);
            burst++;
         end
         position = (position >= POS_ONE) ? position - POS_ONE : '0;
         if (is_last) begin
            if (fill > 0) begin
               w.word = buffer;
               w.last = 1'b1;
               item_words.push_back(w);
            end else if (item_words.size() > 0) begin
               item_words[item_words.size() - 1].last = 1'b1;
            end else begin
               w.word = '0;
               w.last = 1'b1;
               item_words.push_back(w);
            end
            position = '0;
            buffer = '0;
            fill = 0;
         end
         foreach (item_words[i]) expected_words.push_back(item_words[i]);
      endfunction

      task report(string msg);
         $display("ERROR at %0t: %s", $time, msg);
         errors++;
      endtask

      task check_word(logic [WORD_W-1:0] word, logic last);
         packed_result_type want;
         if (expected_words.size() == 0) begin
            report($sformatf("unexpected word %h last %b", word, last));
         end else begin
            want = expected_words.pop_front();
            if (word !== want.word)
               report($sformatf("packed_word got %h want %h", word, want.word));
            if (last !== want.last)
               report($sformatf("last_word got %b want %b (word %h)", last, want.last,
                                want.word));
         end
      endtask

      task report_leftovers();
         while (expected_words.size() > 0) begin
            packed_result_type w;
            w = expected_words.pop_front();
            report($sformatf("missing word %h last %b", w.word, w.last));
         end
      endtask
   endclass

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic [SAMPLE_W-1:0]   req_source_sample = '0;
   logic                  req_last_sample = 1'b0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic [WORD_W-1:0]     rsp_packed_word;
   logic                  rsp_last_word;
   logic                  psel = 1'b0;
   logic                  penable = 1'b0;
   logic                  pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr = '0;
   logic [CSR_DATA_W-1:0] pwdata = '0;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   int send_idle = 0;
   int recv_idle = 0;
   pcm_word_scoreboard sb;

   pcm_rate_converter_packer dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_source_sample (req_source_sample),
      .req_last_sample   (req_last_sample),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_packed_word   (rsp_packed_word),
      .rsp_last_word     (rsp_last_word),
      .psel              (psel),
      .penable           (penable),
      .pwrite            (pwrite),
      .paddr             (paddr),
      .pwdata            (pwdata),
      .prdata            (prdata),
      .pready            (pready)
   );

   always #5 clock = ~clock;

   // Packed word sink: check each transfer, then pick the next ready level.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         sb.check_word(rsp_packed_word, rsp_last_word);
      rsp_ready <= ($urandom_range(0, 99) >= recv_idle);
   end

   task send_sample(logic [SAMPLE_W-1:0] sample, logic last);
      while ($urandom_range(0, 99) < send_idle) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_source_sample <= sample;
      req_last_sample <= last;
      do @(posedge clock); while (!req_ready);
      sb.take_sample(sample, last);
   endtask

   // Hold the source until every queued word is out, then let the block settle.
   task drain();
      int waited;
      waited = 0;
      req_valid <= 1'b0;
      while (sb.pending() != 0 && waited < 20000) begin
         @(posedge clock);
         waited++;
      end
      repeat (12) @(posedge clock);
   endtask

   task csr_write(reg_index_type idx, logic [CSR_DATA_W-1:0] value);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {idx, 2'b00};
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      sb.apply_register(idx, value);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      @(posedge clock);
   endtask

   function logic [CSR_DATA_W-1:0] pick_step();
      case ($urandom_range(0, 15))
         0: return 32'd0;
         1: return 32'd1;
         2: return 32'd16384;
         3: return 32'd262144;
         4: return 32'h7FFFF;
         5: return 32'd65536;
         default: return $urandom_range(16384, 262144);
      endcase
   endfunction

   function logic [SAMPLE_W-1:0] pick_sample();
      case ($urandom_range(0, 15))
         0: return 16'h0000;
         1: return 16'hFFFF;
         2: return 16'h8000;
         3: return 16'h7FFF;
         4: return 16'h0080;
         5: return 16'h007F;
         default: return $urandom_range(0, 65535);
      endcase
   endfunction

   task random_config();
      drain();
      csr_write(REG_STEP_FRAC, pick_step());
      if ($urandom_range(0, 1) == 0)
         csr_write(REG_IN_WIDTH, $urandom_range(0, 3));
      if ($urandom_range(0, 1) == 0)
         csr_write(REG_OUT_WIDTH, $urandom_range(0, 3));
   endtask

   initial begin
      #2_000_000;
      $display("== FAIL ==");
      $finish;
   end

   initial begin
      int  sent;
      int  len;
      int  k;
      bit  paused;
      logic last;
      sb = new();
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      send_idle = 30;
      recv_idle = 78;

      // unknown register index must be ignored
      csr_write(REG_NONE, 32'hFFFF_FFFF);

      // unity rate, 16-bit in and out
      send_sample(16'h0000, 1'b0);
      send_sample(16'hFFFF, 1'b0);
      send_sample(16'h8000, 1'b0);
      send_sample(16'h7FFF, 1'b1);

      // 8-bit in and out, four outputs per source sample
      drain();
      csr_write(REG_IN_WIDTH, WIDTH_BYTE);
      csr_write(REG_OUT_WIDTH, WIDTH_BYTE);
      csr_write(REG_STEP_FRAC, 32'd16384);
      send_sample(16'h0000, 1'b0);
      send_sample(16'hFFFF, 1'b0);
      send_sample(16'h7F80, 1'b0);
      send_sample(16'hAB7F, 1'b1);

      // zero step: burst cap holds the position at zero
      drain();
      csr_write(REG_STEP_FRAC, 32'd0);
      send_sample(16'h1234, 1'b0);
      send_sample(16'h00FF, 1'b1);

      // downsample by two: skipped samples, empty last item gives a zero word
      drain();
      csr_write(REG_IN_WIDTH, WIDTH_HALF);
      csr_write(REG_OUT_WIDTH, WIDTH_HALF);
      csr_write(REG_STEP_FRAC, 32'd131072);
      send_sample(16'h1111, 1'b0);
      send_sample(16'h2222, 1'b0);
      send_sample(16'h3333, 1'b0);
      send_sample(16'h4444, 1'b1);

      // downsample by four with a partial flush
      drain();
      csr_write(REG_STEP_FRAC, 32'd262144);
      send_sample(16'h1111, 1'b0);
      send_sample(16'h2222, 1'b0);
      send_sample(16'h3333, 1'b0);
      send_sample(16'h4444, 1'b1);

      // width change drops a pending partial word
      drain();
      csr_write(REG_STEP_FRAC, 32'd65536);
      send_sample(16'h5A5A, 1'b0);
      drain();
      csr_write(REG_OUT_WIDTH, WIDTH_BYTE);
      send_sample(16'h0102, 1'b1);

      sent = 0;
      paused = 0;
      while (sent < 280) begin
         if (sent < 95) begin
            send_idle = 30;
            recv_idle = 78;
         end else if (sent < 190) begin
            send_idle = 78;
            recv_idle = 30;
         end else begin
            send_idle = 0;
            recv_idle = 0;
         end
         if ($urandom_range(0, 2) != 0)
            random_config();
         len = ($urandom_range(0, 7) == 0) ? $urandom_range(25, 40) : $urandom_range(1, 16);
         for (k = 0; k < len; k++) begin
            last = (k == len - 1 && $urandom_range(0, 4) != 0) ||
                   ($urandom_range(0, 19) == 0);
            send_sample(pick_sample(), last);
            sent++;
            if (sent >= 140 && !paused) begin
               paused = 1;
               drain();
            end
         end
      end

      drain();
      sb.report_leftovers();
      if (sb.errors == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule
